// ----- hdl/mrwc_pkg.sv -----
// shared types and constants for the masked register write coalescer
package mrwc_pkg;

	localparam int DEF_NUM_DEVICES = 4;
	localparam int DEF_NUM_REGS    = 16;

	localparam logic [15:0] WORD_MASK = 16'hffff;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_CHECK = 1'b1;

	typedef enum logic [1:0] {
		OP_QUEUE = 2'd0,
		OP_FLUSH = 2'd1,
		OP_LOAD  = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

	typedef struct packed {
		op_t         opcode;
		logic [1:0]  device;
		logic [3:0]  reg_addr;
		logic        bit_mode;
		logic [3:0]  bit_index;
		logic [15:0] data_in;
		logic [15:0] prev_value;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  out_device;
		logic [3:0]  out_reg;
		logic [15:0] out_data;
		logic        changed;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] mask;
		logic [15:0] value;
		logic [15:0] mirror;
	} entry_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_CLEAR,
		ACT_FL_READ,
		ACT_FL_TAKE,
		ACT_FL_SKIP,
		ACT_FL_FINAL,
		ACT_WRITE,
		ACT_CHECK
	} act_t;

	typedef struct packed {
		act_t act;
	} dp_cmd_t;

	typedef struct packed {
		op_t  req_op;
		logic in_range;
		logic mask_nz;
		logic hold_valid;
		logic out_free;
		logic cnt_last;
	} dp_sts_t;

endpackage

// ----- hdl/mrwc_chan_if.sv -----
// valid/ready channel carrying one request or result
interface mrwc_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/mrwc_ctrl.sv -----
// controller state machine of the coalescer
module mrwc_ctrl import mrwc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  op_t     req_op,
	output logic    req_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ACCESS,
		S_FL_READ,
		S_FL_EVAL,
		S_FL_END
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd.act   = ACT_NONE;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.act = ACT_CLEAR;
				if (sts.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.act = ACT_ACCEPT;
					state_d = (req_op == OP_FLUSH) ? S_FL_READ : S_ACCESS;
				end
			end
			S_ACCESS: begin
				if (!sts.in_range) begin
					state_d = S_IDLE;
				end else if (sts.req_op == OP_CHECK) begin
					if (sts.out_free) begin
						cmd.act = ACT_CHECK;
						state_d = S_IDLE;
					end
				end else begin
					cmd.act = ACT_WRITE;
					state_d = S_IDLE;
				end
			end
			S_FL_READ: begin
				cmd.act = ACT_FL_READ;
				state_d = S_FL_EVAL;
			end
			S_FL_EVAL: begin
				if (!sts.mask_nz) begin
					cmd.act = ACT_FL_SKIP;
					state_d = sts.cnt_last ? S_FL_END : S_FL_READ;
				end else if (!sts.hold_valid || sts.out_free) begin
					cmd.act = ACT_FL_TAKE;
					state_d = sts.cnt_last ? S_FL_END : S_FL_READ;
				end
			end
			S_FL_END: begin
				if (!sts.hold_valid) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.act = ACT_FL_FINAL;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/mrwc_dp.sv -----
// datapath: entry memory, flush counters, hold and result registers
module mrwc_dp import mrwc_pkg::*; #(
	parameter int NUM_DEVICES = DEF_NUM_DEVICES,
	parameter int NUM_REGS    = DEF_NUM_REGS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	input  req_t    req_payload,
	output logic    rsp_valid,
	output rsp_t    rsp_payload,
	input  logic    rsp_ready
);

	localparam int NUM_ENTRIES = NUM_DEVICES * NUM_REGS;
	localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
	localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	entry_t          mem_q [NUM_ENTRIES];
	entry_t          rd_q;
	req_t            req_q;
	logic [AW-1:0]   req_idx_q;
	logic            in_range_q;
	logic [AW-1:0]   cnt_q;
	logic [DW-1:0]   dev_cnt_q;
	logic [RW-1:0]   reg_cnt_q;
	logic            hold_valid_q;
	logic [1:0]      hold_dev_q;
	logic [3:0]      hold_reg_q;
	logic [15:0]     hold_data_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic            in_range;
	logic [31:0]     idx_full;
	logic [AW-1:0]   in_idx;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;
	logic            push;
	rsp_t            push_item;
	logic            cnt_adv;
	logic            out_free;
	logic [15:0]     wmask;
	logic [15:0]     wval;
	logic [15:0]     cur;
	logic [15:0]     ref_val;
	logic [15:0]     merged;

	assign in_range = (32'(req_payload.device) < NUM_DEVICES) &&
		(32'(req_payload.reg_addr) < NUM_REGS);
	assign idx_full = 32'(req_payload.device) * NUM_REGS + 32'(req_payload.reg_addr);
	assign in_idx   = idx_full[AW-1:0];
	assign out_free = !rsp_valid_q || rsp_ready;
	assign merged   = (rd_q.mirror & ~rd_q.mask) | rd_q.value;

	// queued write mask and value
	always_comb begin
		if (req_q.bit_mode) begin
			wmask = 16'h0001 << req_q.bit_index;
			wval  = (req_q.data_in != 16'h0000) ? wmask : 16'h0000;
		end else begin
			wmask = WORD_MASK;
			wval  = req_q.data_in;
		end
	end

	// check comparison
	always_comb begin
		if (req_q.bit_mode) begin
			cur     = {15'h0000, rd_q.mirror[req_q.bit_index]};
			ref_val = {15'h0000, req_q.prev_value != 16'h0000};
		end else begin
			cur     = rd_q.mirror;
			ref_val = req_q.prev_value;
		end
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = cnt_q;
		wr_en     = 1'b0;
		wr_addr   = cnt_q;
		wr_data   = rd_q;
		push      = 1'b0;
		push_item = '{kind: KIND_WRITE, out_device: hold_dev_q, out_reg: hold_reg_q,
			out_data: hold_data_q, changed: 1'b0, last: 1'b0};
		cnt_adv   = 1'b0;
		case (cmd.act)
			ACT_ACCEPT: begin
				rd_en   = in_range;
				rd_addr = in_idx;
			end
			ACT_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
				cnt_adv = 1'b1;
			end
			ACT_FL_READ: begin
				rd_en = 1'b1;
			end
			ACT_FL_TAKE: begin
				wr_en         = 1'b1;
				wr_data.mask  = 16'h0000;
				wr_data.value = 16'h0000;
				cnt_adv       = 1'b1;
				push          = hold_valid_q;
			end
			ACT_FL_SKIP: begin
				cnt_adv = 1'b1;
			end
			ACT_FL_FINAL: begin
				push           = 1'b1;
				push_item.last = 1'b1;
			end
			ACT_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = req_idx_q;
				if (req_q.opcode == OP_LOAD) begin
					wr_data.mirror = req_q.data_in;
				end else begin
					wr_data.mask  = rd_q.mask | wmask;
					wr_data.value = (rd_q.value & ~wmask) | (wval & wmask);
				end
			end
			ACT_CHECK: begin
				push      = 1'b1;
				push_item = '{kind: KIND_CHECK, out_device: req_q.device,
					out_reg: req_q.reg_addr, out_data: cur,
					changed: cur != ref_val, last: 1'b1};
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			dev_cnt_q    <= '0;
			reg_cnt_q    <= '0;
			hold_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			in_range_q   <= 1'b0;
		end else begin
			if (cmd.act == ACT_ACCEPT) begin
				cnt_q      <= '0;
				dev_cnt_q  <= '0;
				reg_cnt_q  <= '0;
				in_range_q <= in_range;
			end else if (cnt_adv) begin
				cnt_q <= cnt_q + 1'b1;
				if (32'(reg_cnt_q) == NUM_REGS - 1) begin
					reg_cnt_q <= '0;
					dev_cnt_q <= dev_cnt_q + 1'b1;
				end else begin
					reg_cnt_q <= reg_cnt_q + 1'b1;
				end
			end
			if (cmd.act == ACT_FL_TAKE) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.act == ACT_FL_FINAL) begin
				hold_valid_q <= 1'b0;
			end
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.act == ACT_ACCEPT) begin
			req_q     <= req_payload;
			req_idx_q <= in_idx;
		end
		if (cmd.act == ACT_FL_TAKE) begin
			hold_dev_q  <= 2'(dev_cnt_q);
			hold_reg_q  <= 4'(reg_cnt_q);
			hold_data_q <= merged;
		end
		if (push) begin
			rsp_q <= push_item;
		end
	end

	assign sts.req_op     = req_q.opcode;
	assign sts.in_range   = in_range_q;
	assign sts.mask_nz    = rd_q.mask != 16'h0000;
	assign sts.hold_valid = hold_valid_q;
	assign sts.out_free   = out_free;
	assign sts.cnt_last   = cnt_q == AW'(NUM_ENTRIES - 1);

	assign rsp_valid   = rsp_valid_q;
	assign rsp_payload = rsp_q;

`ifndef SYNTHESIS
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result register overwritten");
	a_final_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == ACT_FL_FINAL |-> hold_valid_q)
		else $error("final flush result without held entry");
	a_take_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == ACT_FL_TAKE |=> hold_valid_q)
		else $error("held entry lost after take");
	a_check_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.kind == KIND_CHECK |-> rsp_q.last)
		else $error("check result not marked last");
`endif

endmodule

// ----- hdl/masked_register_write_coalescer_top.sv -----
// masked register write coalescer top level
//
//   channel  role    payload  accepted when
//   req_ch   sink    req_t    req_ch.valid && req_ch.ready
//   rsp_ch   source  rsp_t    rsp_ch.valid && rsp_ch.ready
//
// queue, load and check first read the entry memory, then write the entry back or register
// the check result
// flush reads each entry in turn; an entry with a nonzero mask is cleared and its value held
// after reset a clearing pass zeroes every entry of the memory, no request
// is taken meanwhile
// a stalled result register holds flush and check until rsp_ch is ready
module masked_register_write_coalescer_top import mrwc_pkg::*; #(
	parameter int NUM_DEVICES = DEF_NUM_DEVICES,
	parameter int NUM_REGS    = DEF_NUM_REGS
) (
	input logic          clk,
	input logic          arst_n,
	mrwc_chan_if.sink    req_ch,
	mrwc_chan_if.source  rsp_ch
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	req_t    req_payload;
	rsp_t    rsp_payload;
	logic    req_ready;
	logic    rsp_valid;

	assign req_payload     = req_ch.payload;
	assign req_ch.ready    = req_ready;
	assign rsp_ch.valid    = rsp_valid;
	assign rsp_ch.payload  = rsp_payload;

	mrwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_op    (req_payload.opcode),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mrwc_dp #(
		.NUM_DEVICES (NUM_DEVICES),
		.NUM_REGS    (NUM_REGS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_payload (req_payload),
		.rsp_valid   (rsp_valid),
		.rsp_payload (rsp_payload),
		.rsp_ready   (rsp_ch.ready)
	);

endmodule
